[rtl/csm_pkg.sv]
// Types and constants shared by the CPU schedule metrics block.
package csm_pkg;

   localparam logic [1:0] MODE_FCFS = 2'd0;
   localparam logic [1:0] MODE_RR   = 2'd1;
   localparam logic [1:0] MODE_SJF  = 2'd2;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_SLICE = 2'd1;

   localparam logic [1:0]  MODE_RESET  = 2'd2;
   localparam logic [15:0] SLICE_RESET = 16'd2;

   typedef struct packed {
      logic [15:0] pid;
      logic [15:0] burst_time;
      logic [15:0] arrival_time;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [15:0] pid_res;
      logic [20:0] completion_time;
      logic [20:0] turnaround_time;
      logic [20:0] waiting_time;
      logic [20:0] response_time;
      logic [24:0] total_turnaround;
      logic [24:0] total_waiting;
      logic [24:0] total_response;
      logic [4:0]  process_count;
      logic        last_result;
   } rsp_type;

endpackage

[rtl/cpu_schedule_metrics.sv]
// Batch CPU scheduler that reports per-process timing metrics.
//
// Usage: load process records on the req_ channel, one per cycle while busy is low
// (a transfer happens when start is high and busy is low). Records beyond
// MAX_ENTRIES are dropped. A record with is_last set closes the batch; busy then
// rises and the block schedules the batch under the mode register (first come
// first served, round robin, shortest job first) starting from time 0.
// Scheduling visits one store entry per cycle. FCFS makes one sweep over the store,
// SJF one sweep per pick plus one per idle jump, round robin repeated sweeps plus
// one per idle jump; the single entry-wide datapath does these sweeps.
// Results then appear one per cycle in load order on the rsp_ port, each shown
// for one cycle with rsp_valid; the last carries the batch sums and count.
// The receiver cannot stall. Configuration is written on the csr_ channel,
// which is always ready. Synchronous reset clears control state and sets
// mode to shortest job first and time_slice to 2.
module cpu_schedule_metrics
   import csm_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_RUN  = 3'd1;
   localparam logic [2:0] ST_JUMP = 3'd2;
   localparam logic [2:0] ST_SJFX = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // per-entry stores
   logic [15:0] pid_mem [MAX_ENTRIES];
   logic [15:0] arr_mem [MAX_ENTRIES];
   logic [15:0] bur_mem [MAX_ENTRIES];
   logic [15:0] rem_mem [MAX_ENTRIES];
   logic [20:0] fin_mem [MAX_ENTRIES];
   logic [20:0] fst_mem [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] done_ff, started_ff;

   logic [2:0]    state_ff;
   logic [1:0]    mode_ff;
   logic [15:0]   slice_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] fin_cnt_ff;
   logic [IW-1:0] idx_ff;
   logic [20:0]   now_ff;
   logic          served_ff;
   logic          found_ff;
   logic [IW-1:0] pick_ff;
   logic [15:0]   best_ff;
   logic [24:0]   sum_tat_ff, sum_wait_ff, sum_resp_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic          last_idx;
   logic [15:0]   slice;
   logic [15:0]   a_i, b_i, r_i;
   logic          elig;
   logic          jmp_hit, sjf_hit;
   logic [20:0]   tat, wt, rsp_t;

   assign last_idx = ({{(CW-IW){1'b0}}, idx_ff} + 1'b1) == count_ff;
   assign slice    = (slice_ff == 16'd0) ? 16'd1 : slice_ff;
   assign a_i      = arr_mem[idx_ff];
   assign b_i      = bur_mem[idx_ff];
   assign r_i      = rem_mem[idx_ff];
   assign elig     = !done_ff[idx_ff] && ({5'd0, a_i} <= now_ff);
   assign jmp_hit  = !done_ff[idx_ff] && (!found_ff || a_i < best_ff);
   assign sjf_hit  = elig && (!found_ff || b_i < best_ff);
   assign tat      = fin_mem[idx_ff] - {5'd0, a_i};
   assign wt       = tat - {5'd0, b_i};
   assign rsp_t    = fst_mem[idx_ff] - {5'd0, a_i};

   assign busy      = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         slice_ff <= SLICE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_MODE) mode_ff <= csr_data[1:0];
         else if (csr_index == REG_SLICE) slice_ff <= csr_data;
      end
   end

   // sequencer and shared entry datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         fin_cnt_ff <= '0;
         idx_ff     <= '0;
         done_ff    <= '0;
         started_ff <= '0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_OUT);
         case (state_ff)
            ST_LOAD: begin
               if (start) begin
                  if (count_ff < CW'(MAX_ENTRIES)) begin
                     pid_mem[count_ff[IW-1:0]] <= req_data.pid;
                     bur_mem[count_ff[IW-1:0]] <= req_data.burst_time;
                     rem_mem[count_ff[IW-1:0]] <= req_data.burst_time;
                     arr_mem[count_ff[IW-1:0]] <= req_data.arrival_time;
                     count_ff <= count_ff + 1'b1;
                  end
                  if (req_data.is_last) begin
                     if (count_ff == '0 && !(count_ff < CW'(MAX_ENTRIES))) begin
                        state_ff <= ST_LOAD;
                     end else begin
                        state_ff <= (mode_ff == MODE_FCFS) ? ST_RUN :
                                    (mode_ff == MODE_RR) ? ST_RUN : ST_SJFX;
                     end
                     idx_ff      <= '0;
                     now_ff      <= '0;
                     fin_cnt_ff  <= '0;
                     done_ff     <= '0;
                     started_ff  <= '0;
                     served_ff   <= 1'b0;
                     found_ff    <= 1'b0;
                     sum_tat_ff  <= '0;
                     sum_wait_ff <= '0;
                     sum_resp_ff <= '0;
                  end
               end
            end
            ST_RUN: begin
               if (mode_ff == MODE_FCFS) begin
                  // run entry in load order
                  if (now_ff < {5'd0, a_i}) begin
                     fst_mem[idx_ff] <= {5'd0, a_i};
                     fin_mem[idx_ff] <= {5'd0, a_i} + {5'd0, b_i};
                     now_ff <= {5'd0, a_i} + {5'd0, b_i};
                  end else begin
                     fst_mem[idx_ff] <= now_ff;
                     fin_mem[idx_ff] <= now_ff + {5'd0, b_i};
                     now_ff <= now_ff + {5'd0, b_i};
                  end
                  idx_ff <= last_idx ? '0 : idx_ff + 1'b1;
                  if (last_idx) state_ff <= ST_OUT;
               end else begin
                  // one round robin visit
                  if (elig) begin
                     if (!started_ff[idx_ff]) begin
                        started_ff[idx_ff] <= 1'b1;
                        fst_mem[idx_ff] <= now_ff;
                     end
                     if (r_i > slice) begin
                        rem_mem[idx_ff] <= r_i - slice;
                        now_ff <= now_ff + {5'd0, slice};
                     end else begin
                        rem_mem[idx_ff] <= '0;
                        done_ff[idx_ff] <= 1'b1;
                        fin_mem[idx_ff] <= now_ff + {5'd0, r_i};
                        now_ff <= now_ff + {5'd0, r_i};
                        fin_cnt_ff <= fin_cnt_ff + 1'b1;
                     end
                  end
                  served_ff <= last_idx ? 1'b0 : (served_ff || elig);
                  if (last_idx) begin
                     idx_ff <= '0;
                     if (fin_cnt_ff + CW'(elig && !(r_i > slice)) == count_ff)
                        state_ff <= ST_OUT;
                     else if (!(served_ff || elig)) begin
                        state_ff <= ST_JUMP;
                        found_ff <= 1'b0;
                     end
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_JUMP: begin
               // find earliest unfinished arrival
               if (jmp_hit) best_ff <= a_i;
               found_ff <= !last_idx && (found_ff || jmp_hit);
               if (last_idx) begin
                  idx_ff <= '0;
                  if (jmp_hit) begin
                     if ({5'd0, a_i} > now_ff) now_ff <= {5'd0, a_i};
                  end else if (found_ff && {5'd0, best_ff} > now_ff) begin
                     now_ff <= {5'd0, best_ff};
                  end
                  state_ff <= (mode_ff == MODE_RR) ? ST_RUN : ST_SJFX;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_SJFX: begin
               // scan for shortest ready job, then retire it, or jump ahead if none is ready
               if (sjf_hit) begin
                  best_ff <= b_i;
                  pick_ff <= idx_ff;
               end
               found_ff <= !last_idx && (found_ff || sjf_hit);
               if (last_idx) begin
                  idx_ff   <= '0;
                  if (sjf_hit) begin
                     done_ff[idx_ff] <= 1'b1;
                     fst_mem[idx_ff] <= now_ff;
                     fin_mem[idx_ff] <= now_ff + {5'd0, b_i};
                     now_ff <= now_ff + {5'd0, b_i};
                     fin_cnt_ff <= fin_cnt_ff + 1'b1;
                     if (fin_cnt_ff + 1'b1 == count_ff) state_ff <= ST_OUT;
                  end else if (found_ff) begin
                     done_ff[pick_ff] <= 1'b1;
                     fst_mem[pick_ff] <= now_ff;
                     fin_mem[pick_ff] <= now_ff + {5'd0, best_ff};
                     now_ff <= now_ff + {5'd0, best_ff};
                     fin_cnt_ff <= fin_cnt_ff + 1'b1;
                     if (fin_cnt_ff + 1'b1 == count_ff) state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_JUMP;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_OUT: begin
               // emit one result per entry
               sum_tat_ff  <= sum_tat_ff + {4'd0, tat};
               sum_wait_ff <= sum_wait_ff + {4'd0, wt};
               sum_resp_ff <= sum_resp_ff + {4'd0, rsp_t};
               rsp_ff.pid_res         <= pid_mem[idx_ff];
               rsp_ff.completion_time <= fin_mem[idx_ff];
               rsp_ff.turnaround_time <= tat;
               rsp_ff.waiting_time    <= wt;
               rsp_ff.response_time   <= rsp_t;
               rsp_ff.total_turnaround <= last_idx ? sum_tat_ff + {4'd0, tat} : '0;
               rsp_ff.total_waiting    <= last_idx ? sum_wait_ff + {4'd0, wt} : '0;
               rsp_ff.total_response   <= last_idx ? sum_resp_ff + {4'd0, rsp_t} : '0;
               rsp_ff.process_count    <= last_idx ? 5'(count_ff) : 5'd0;
               rsp_ff.last_result      <= last_idx;
               if (last_idx) begin
                  state_ff <= ST_LOAD;
                  count_ff <= '0;
                  idx_ff   <= '0;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule

[rtl/csm_checker.sv]
// Port-level checks for the CPU schedule metrics block and its bind.
module csm_checker
   import csm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // results only come while busy or just after
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result outside batch");

   // a last result ends the batch
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_result |-> !busy) else $error("busy after last");

   // count zero on non-final results
   a_sum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |-> rsp_data.process_count == 5'd0)
      else $error("count on non-final result");

   // waiting never exceeds turnaround
   a_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.waiting_time <= rsp_data.turnaround_time)
      else $error("waiting above turnaround");

   // a batch only starts on a record transfer
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start)) else $error("busy without transfer");

endmodule

bind cpu_schedule_metrics csm_checker u_csm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

[sim/tb.sv]
// Self-checking testbench for the CPU schedule metrics block.
`timescale 1ns / 1ps

module tb;
   import csm_pkg::*;

   localparam int STORE_DEPTH = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_MODE;
   logic [15:0] csr_data = '0;

   req_type     pending_records[$];
   rsp_type     expected_metrics[$];
   int          sender_idle_pct = 0;
   int          error_count = 0;
   int          batch_count = 0;
   int          result_count = 0;

   // Predictor copy of configuration and record store
   logic [1:0]  cur_mode = MODE_RESET;
   logic [15:0] cur_slice = SLICE_RESET;
   logic [15:0] st_pid [STORE_DEPTH];
   logic [15:0] st_arr [STORE_DEPTH];
   logic [15:0] st_burst [STORE_DEPTH];
   int          st_count = 0;

   cpu_schedule_metrics dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Schedule the stored batch and queue one expected result per entry
   task automatic schedule_batch();
      int unsigned now;
      int unsigned fin [STORE_DEPTH];
      int unsigned first [STORE_DEPTH];
      int unsigned rem [STORE_DEPTH];
      bit          done [STORE_DEPTH];
      bit          started [STORE_DEPTH];
      int unsigned slice;
      int unsigned best;
      int unsigned tat, wt, resp, sum_t, sum_w, sum_r;
      int          n, finished, pick;
      bit          served, found;
      rsp_type     r;
      n = st_count;
      now = 0;
      finished = 0;
      sum_t = 0;
      sum_w = 0;
      sum_r = 0;
      slice = (cur_slice == 0) ? 1 : cur_slice;
      for (int i = 0; i < n; i++) begin
         rem[i] = st_burst[i];
         done[i] = 0;
         started[i] = 0;
      end
      if (cur_mode == MODE_FCFS) begin
         for (int i = 0; i < n; i++) begin
            if (now < st_arr[i]) now = st_arr[i];
            first[i] = now;
            now += st_burst[i];
            fin[i] = now;
         end
      end else begin
         while (finished < n) begin
            served = 0;
            found = 0;
            pick = 0;
            if (cur_mode == MODE_RR) begin
               // One sweep in load order, each ready entry gets up to a slice
               for (int i = 0; i < n; i++) begin
                  if (done[i] || st_arr[i] > now) continue;
                  if (!started[i]) begin
                     started[i] = 1;
                     first[i] = now;
                  end
                  served = 1;
                  if (rem[i] > slice) begin
                     rem[i] -= slice;
                     now += slice;
                  end else begin
                     now += rem[i];
                     rem[i] = 0;
                     done[i] = 1;
                     fin[i] = now;
                     finished++;
                  end
               end
            end else begin
               // Shortest arrived burst, earliest loaded wins a tie
               for (int i = 0; i < n; i++) begin
                  if (done[i] || st_arr[i] > now) continue;
                  if (!found || st_burst[i] < st_burst[pick]) begin
                     pick = i;
                     found = 1;
                  end
               end
               if (found) begin
                  served = 1;
                  first[pick] = now;
                  now += st_burst[pick];
                  done[pick] = 1;
                  fin[pick] = now;
                  finished++;
               end
            end
            // Idle CPU: jump to the earliest pending arrival
            if (!served) begin
               found = 0;
               best = 0;
               for (int i = 0; i < n; i++)
                  if (!done[i] && (!found || st_arr[i] < best)) begin
                     best = st_arr[i];
                     found = 1;
                  end
               if (found && best > now) now = best;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         tat = fin[i] - st_arr[i];
         wt = tat - st_burst[i];
         resp = first[i] - st_arr[i];
         sum_t += tat;
         sum_w += wt;
         sum_r += resp;
         r = '0;
         r.pid_res = st_pid[i];
         r.completion_time = fin[i][20:0];
         r.turnaround_time = tat[20:0];
         r.waiting_time = wt[20:0];
         r.response_time = resp[20:0];
         if (i == n - 1) begin
            r.total_turnaround = sum_t[24:0];
            r.total_waiting = sum_w[24:0];
            r.total_response = sum_r[24:0];
            r.process_count = n[4:0];
            r.last_result = 1'b1;
         end
         expected_metrics.push_back(r);
      end
      st_count = 0;
      batch_count++;
   endtask

   // Driver: predict on each accepted transfer, then present the next record
   always @(posedge clock) begin
      bit accepted;
      accepted = 0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            accepted = 1;
            if (st_count < STORE_DEPTH) begin
               st_pid[st_count] = req_data.pid;
               st_burst[st_count] = req_data.burst_time;
               st_arr[st_count] = req_data.arrival_time;
               st_count++;
            end
            if (req_data.is_last) schedule_batch();
         end
         if (!start || accepted) begin
            if (pending_records.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               start <= 1'b1;
               req_data <= pending_records.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_metrics.size() == 0) begin
            report("unexpected result, pid", rsp_data.pid_res, -1);
         end else begin
            want = expected_metrics.pop_front();
            result_count++;
            if (rsp_data.pid_res !== want.pid_res)
               report("pid_res", rsp_data.pid_res, want.pid_res);
            if (rsp_data.completion_time !== want.completion_time)
               report("completion_time", rsp_data.completion_time, want.completion_time);
            if (rsp_data.turnaround_time !== want.turnaround_time)
               report("turnaround_time", rsp_data.turnaround_time, want.turnaround_time);
            if (rsp_data.waiting_time !== want.waiting_time)
               report("waiting_time", rsp_data.waiting_time, want.waiting_time);
            if (rsp_data.response_time !== want.response_time)
               report("response_time", rsp_data.response_time, want.response_time);
            if (rsp_data.total_turnaround !== want.total_turnaround)
               report("total_turnaround", rsp_data.total_turnaround, want.total_turnaround);
            if (rsp_data.total_waiting !== want.total_waiting)
               report("total_waiting", rsp_data.total_waiting, want.total_waiting);
            if (rsp_data.total_response !== want.total_response)
               report("total_response", rsp_data.total_response, want.total_response);
            if (rsp_data.process_count !== want.process_count)
               report("process_count", rsp_data.process_count, want.process_count);
            if (rsp_data.last_result !== want.last_result)
               report("last_result", rsp_data.last_result, want.last_result);
         end
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_records.size() > 0 || start || expected_metrics.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_MODE) cur_mode = val[1:0];
      else if (idx == REG_SLICE) cur_slice = val;
   endtask

   task automatic push_record(input logic [15:0] pid, input logic [15:0] burst,
                              input logic [15:0] arr, input logic last);
      req_type r;
      r.pid = pid;
      r.burst_time = burst;
      r.arrival_time = arr;
      r.is_last = last;
      pending_records.push_back(r);
   endtask

   // Random batch; round-robin bursts are kept within eight slices
   task automatic push_batch(input int n);
      int maxb, maxa;
      maxb = 65535;
      if (cur_mode == MODE_RR) maxb = (cur_slice == 0 ? 1 : cur_slice) * 8;
      if (maxb > 65535) maxb = 65535;
      if ($urandom_range(3) == 0) maxb = (maxb < 20) ? maxb : 20;
      maxa = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1, 200);
      for (int i = 0; i < n; i++)
         push_record(16'($urandom_range(65535)), 16'($urandom_range(maxb)),
                     16'($urandom_range(maxa)), i == n - 1);
   endtask

   initial begin
      int items;
      int n;
      logic [1:0]  phase_mode [8] = '{MODE_FCFS, MODE_RR, MODE_SJF, MODE_RR,
                                      2'd3, MODE_RR, MODE_FCFS, MODE_RR};
      logic [15:0] phase_slice [8] = '{16'd5, 16'd0, 16'd1, 16'd65535,
                                       16'd7, 16'd3, 16'd100, 16'd1};
      int          phase_idle [8] = '{0, 62, 13, 0, 62, 13, 0, 62};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings (shortest job first, slice 2), idle gap, ties
      push_record(16'h0000, 16'd4, 16'd0, 1'b0);
      push_record(16'hFFFF, 16'd2, 16'd1, 1'b0);
      push_record(16'h1234, 16'd2, 16'd1, 1'b0);
      push_record(16'h00A5, 16'd3, 16'd50, 1'b1);
      wait_drained();
      write_reg(REG_SLICE, 16'd2);
      write_reg(REG_MODE, 16'(MODE_FCFS));
      // Extremes and zero burst, single-record batch
      push_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      push_record(16'h0000, 16'd0, 16'd0, 1'b1);
      push_record(16'h5A5A, 16'd0, 16'd7, 1'b1);
      wait_drained();
      write_reg(REG_MODE, 16'(MODE_RR));
      push_record(16'd1, 16'd5, 16'd0, 1'b0);
      push_record(16'd2, 16'd0, 16'd2, 1'b0);
      push_record(16'd3, 16'd3, 16'd30, 1'b1);
      // Overflow: 18 records, the is_last on a dropped record still closes
      wait_drained();
      write_reg(REG_MODE, 16'(MODE_SJF));
      for (int i = 0; i < 18; i++)
         push_record(16'(100 + i), 16'($urandom_range(20)), 16'($urandom_range(30)), i == 17);
      wait_drained();

      // Random phases across settings and sender idling
      for (int p = 0; p < 8; p++) begin
         write_reg(REG_MODE, 16'(phase_mode[p]));
         write_reg(REG_SLICE, phase_slice[p]);
         sender_idle_pct = phase_idle[p];
         items = 0;
         while (items < 25) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 8);
            push_batch(n);
            items += n;
         end
         wait_drained();
      end

      $display("Checked %0d batches, %0d results over FCFS, round robin and SJF",
               batch_count, result_count);
      $display("with slices from 0 to 65535 and store overflow.");
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
rtl/csm_pkg.sv
rtl/cpu_schedule_metrics.sv
rtl/csm_checker.sv
sim/tb.sv
